// File: sv/sat_pkg.sv
// Shared types and constants for the summed-area table engine.
`default_nettype none
package sat_pkg;
  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_ADD   = 3'd1,
    OP_CUM   = 3'd2,
    OP_QRECT = 3'd3,
    OP_QCELL = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORNER,
    ST_WAIT,
    ST_FINISH,
    ST_CUM_RD,
    ST_CUM_LAT,
    ST_CUM_WR
  } state_t;

  localparam logic CfgSizeX = 1'b0;
endpackage
`default_nettype wire

// File: sv/sat_mem.sv
// Single-port synchronous table memory with a registered read.
`default_nettype none
module sat_mem
  import sat_pkg::*;
#(
  parameter int unsigned DEPTH = 4225,
  parameter int unsigned AW = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [63:0]   wdata,
  output logic      [63:0]   rdata
);
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/summed_area_table_engine.sv
// Top level of the summed-area table engine: control sequencer around one table memory.
`default_nettype none
// Flow: a write, every rejected item and an empty add-rectangle go from acceptance to the
// finish state; add-rectangle and both queries visit four corners, with corner and wait
// states for each corner accessed and the corner state alone for a skipped one, then finish.
// Cumulate walks the used region once through read, latency and write states per cell,
// reading the row above from the table and holding left and diagonal neighbors in registers.
// One item at a time. After rst a clearing pass zeroes all (MAX_ROWS+1)*(MAX_COLS+1) entries.
module summed_area_table_engine
  import sat_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         opcode,
  input  wire logic [6:0]         x_low,
  input  wire logic [6:0]         y_low,
  input  wire logic [6:0]         x_high,
  input  wire logic [6:0]         y_high,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic signed [63:0]      sum,
  output logic                    status,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [6:0]         cfg_data
);
  localparam int unsigned Stride = MAX_COLS + 1;
  localparam int unsigned Depth = (MAX_ROWS + 1) * Stride;
  localparam int unsigned AW = $clog2(Depth);

  // Size registers, clamped to 1..MAX on write.
  logic [6:0] size_x, size_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= (MAX_ROWS < 64) ? 7'(MAX_ROWS) : 7'd64;
      size_y <= (MAX_COLS < 64) ? 7'(MAX_COLS) : 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CfgSizeX) begin
        size_x <= (cfg_data == 7'd0) ? 7'd1 :
                  (32'(cfg_data) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg_data;
      end else begin
        size_y <= (cfg_data == 7'd0) ? 7'd1 :
                  (32'(cfg_data) > MAX_COLS) ? 7'(MAX_COLS) : cfg_data;
      end
    end
  end

  // Latched item and working registers.
  op_t         op;
  logic [6:0]  xl, yl, xh, yh;
  logic [63:0] val;
  logic [63:0] acc;
  logic [1:0]  corner;
  logic [6:0]  cx, cy;
  logic [AW-1:0] clr_addr;
  logic [63:0] own;       // current cell before it is cumulated
  logic [63:0] left;      // cumulated cell to the left
  logic [63:0] diag;      // cumulated cell above-left

  state_t state, state_next;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0]   mem_wdata, mem_rdata;

  sat_mem #(.DEPTH(Depth), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  function automatic logic [AW-1:0] addr_of(input logic [6:0] x, input logic [6:0] y);
    return AW'(32'(x) * Stride + 32'(y));
  endfunction

  // Corner selection: for each of four corners, coordinates, sign and enable.
  logic [6:0] kx, ky;
  logic       kneg, ken;
  always_comb begin
    kx = xh; ky = yh; kneg = 1'b0; ken = 1'b1;
    if (op == OP_ADD) begin
      case (corner)
        2'd0: begin kx = xl + 7'd1; ky = yl + 7'd1; end
        2'd1: begin
          kx = xh + 7'd1; ky = yl + 7'd1; kneg = 1'b1;
          ken = ({1'b0, xh} + 8'd1) <= {1'b0, size_x};
        end
        2'd2: begin
          kx = xl + 7'd1; ky = yh + 7'd1; kneg = 1'b1;
          ken = ({1'b0, yh} + 8'd1) <= {1'b0, size_y};
        end
        default: begin
          kx = xh + 7'd1; ky = yh + 7'd1;
          ken = (({1'b0, xh} + 8'd1) <= {1'b0, size_x}) &&
                (({1'b0, yh} + 8'd1) <= {1'b0, size_y});
        end
      endcase
    end else begin
      case (corner)
        2'd0: begin kx = xh; ky = yh; end
        2'd1: begin kx = xl; ky = yh; kneg = 1'b1; end
        2'd2: begin kx = xh; ky = yl; kneg = 1'b1; end
        default: begin kx = xl; ky = yl; end
      endcase
    end
  end

  // Input checks at start.
  logic pt_ok, rc_ok, in_ok, empty_rect;
  always_comb begin
    pt_ok = (x_high != 7'd0) && (x_high <= size_x) &&
            (y_high != 7'd0) && (y_high <= size_y);
    rc_ok = (x_low <= x_high) && (x_high <= size_x) &&
            (y_low <= y_high) && (y_high <= size_y);
    empty_rect = (x_low == x_high) || (y_low == y_high);
    case (opcode)
      OP_WRITE, OP_QCELL: in_ok = pt_ok;
      OP_ADD, OP_QRECT:   in_ok = rc_ok;
      OP_CUM:             in_ok = 1'b1;
      default:            in_ok = 1'b0;
    endcase
  end

  // In the cumulate write cycle the memory returns the already cumulated cell above.
  logic [63:0] cum_val;
  assign cum_val = own + mem_rdata + left - diag;

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_addr = addr_of(kx, ky);
    mem_wdata = kneg ? (mem_rdata - val) : (mem_rdata + val);
    busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1; mem_addr = clr_addr; mem_wdata = 64'd0;
        if (32'(clr_addr) == Depth - 1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        mem_addr = addr_of(x_high, y_high);
        mem_wdata = val;
        if (start) begin
          if (!in_ok) state_next = ST_FINISH;
          else if (opcode == OP_WRITE) state_next = ST_FINISH;
          else if (opcode == OP_CUM) state_next = ST_CUM_RD;
          else if ((opcode == OP_ADD) && empty_rect) state_next = ST_FINISH;
          else state_next = ST_CORNER;
        end
      end
      ST_CORNER: begin
        if (ken) state_next = ST_WAIT;
        else if (corner == 2'd3) state_next = ST_FINISH;
      end
      ST_WAIT: begin
        mem_we = (op == OP_ADD);
        state_next = (corner == 2'd3) ? ST_FINISH : ST_CORNER;
      end
      ST_FINISH: begin
        mem_addr = addr_of(xh, yh);
        mem_wdata = val;
        mem_we = (op == OP_WRITE) && !status;
        state_next = ST_IDLE;
      end
      ST_CUM_RD: begin
        mem_addr = addr_of(cx, cy);
        state_next = ST_CUM_LAT;
      end
      ST_CUM_LAT: begin
        mem_addr = addr_of(cx - 7'd1, cy);
        state_next = ST_CUM_WR;
      end
      ST_CUM_WR: begin
        mem_addr = addr_of(cx, cy);
        mem_we = 1'b1;
        mem_wdata = cum_val;
        if ((cy == size_y) && (cx == size_x)) state_next = ST_FINISH;
        else state_next = ST_CUM_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result strobe comes out of FINISH; sum and status are held registers.
  logic qry;
  assign qry = (op == OP_QRECT) || (op == OP_QCELL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_FINISH);
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          op <= op_t'(opcode);
          xl <= (opcode == OP_QCELL) ? x_high - 7'd1 : x_low;
          yl <= (opcode == OP_QCELL) ? y_high - 7'd1 : y_low;
          xh <= x_high; yh <= y_high;
          val <= {{32{value[31]}}, value};
          status <= !in_ok;
          acc <= 64'd0;
          corner <= 2'd0;
          cx <= 7'd1; cy <= 7'd1;
          left <= 64'd0; diag <= 64'd0;
        end
      end
      ST_CORNER: begin
        if (!ken) corner <= corner + 2'd1;
      end
      ST_WAIT: begin
        acc <= kneg ? (acc - mem_rdata) : (acc + mem_rdata);
        corner <= corner + 2'd1;
      end
      ST_FINISH: begin
        sum <= (qry && !status) ? acc : 64'd0;
      end
      ST_CUM_LAT: begin
        own <= mem_rdata;
      end
      ST_CUM_WR: begin
        if (cy == size_y) begin
          cy <= 7'd1; cx <= cx + 7'd1;
          left <= 64'd0; diag <= 64'd0;
        end else begin
          cy <= cy + 7'd1;
          left <= cum_val;
          diag <= mem_rdata;
        end
      end
      default: ;
    endcase
  end

  // A result strobe only follows the finish state.
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_FINISH) else $error("done without finish");
  // No item is taken while the clearing pass runs.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> busy) else $error("idle during clear");
  // Errors never report a nonzero sum.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> sum == 64'd0) else $error("error with sum");
endmodule
`default_nettype wire
